// File: rtl/erle_pkg.sv
// Shared types, constants and helper functions for the escape-byte RLE encoder.
// Used by erle_front, erle_queue, erle_back and the top level; depends on nothing.
package erle_pkg;

    // Byte that opens an escape triple, and the longest run one triple can carry.
    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
    localparam logic [7:0] RUN_CAP     = 8'hFF;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte position within one queued request: at most two triples, six bytes.
    localparam int POS_W = 3;

    // Position codes within one run.
    localparam logic [1:0] RUN_POS_ESC   = 2'd0;
    localparam logic [1:0] RUN_POS_COUNT = 2'd1;
    localparam logic [1:0] RUN_POS_VALUE = 2'd2;

    // One finished run.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] length;
    } run_t;

    // One queued request: the runs closed by one input byte.
    typedef struct packed {
        run_t first_run;
        run_t second_run;
        logic two_runs;
        logic stream_end;
    } emit_cmd_t;

    // A run is sent as a triple when it repeats, or when its byte is the escape itself.
    function automatic logic is_triple(run_t r);
        return (r.length > 8'd1) || (r.value == ESCAPE_BYTE);
    endfunction

    // Number of output bytes one run takes.
    function automatic logic [POS_W-1:0] run_bytes(run_t r);
        return is_triple(r) ? POS_W'(3) : POS_W'(1);
    endfunction

    // Output byte at a given position within one run.
    function automatic logic [7:0] run_byte(run_t r, logic [1:0] idx);
        logic [7:0] b;
        b = r.value;
        if (is_triple(r))
        begin
            case (idx)
                RUN_POS_ESC:   b = ESCAPE_BYTE;
                RUN_POS_COUNT: b = r.length;
                default:       b = r.value;
            endcase
        end
        return b;
    endfunction

endpackage

// File: rtl/erle_front.sv
// Front part of the escape-byte RLE encoder: accepts input bytes, tracks the open run
// and turns each closed run into a request for the queue. Depends on erle_pkg.
module erle_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  logic                queue_full,
    output logic                push,
    output erle_pkg::emit_cmd_t push_cmd
);

    logic [7:0] held_value_reg, held_value_next;
    logic [7:0] run_length_reg, run_length_next;
    logic       run_open_reg,   run_open_next;

    logic                accept;
    logic                close_held;
    erle_pkg::run_t      held_run;
    erle_pkg::run_t      new_run;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Classify the incoming byte against the open run.
    always_comb
    begin
        held_run.value  = held_value_reg;
        held_run.length = run_length_reg;

        close_held = run_open_reg &&
                     ((in_byte != held_value_reg) || (run_length_reg >= erle_pkg::RUN_CAP));

        // Run as it stands after this byte.
        if (run_open_reg && !close_held)
        begin
            new_run.value  = held_value_reg;
            new_run.length = run_length_reg + 8'd1;
        end
        else
        begin
            new_run.value  = in_byte;
            new_run.length = 8'd1;
        end

        // Build the request: the closed run first, then the final run at stream end.
        push_cmd.stream_end = in_end;
        if (close_held)
        begin
            push_cmd.first_run  = held_run;
            push_cmd.second_run = new_run;
            push_cmd.two_runs   = in_end;
        end
        else
        begin
            push_cmd.first_run  = new_run;
            push_cmd.second_run = new_run;
            push_cmd.two_runs   = 1'b0;
        end
        push = accept && (close_held || in_end);

        // Next run state; the end of the stream leaves no run held.
        held_value_next = held_value_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        if (accept)
        begin
            held_value_next = new_run.value;
            run_length_next = in_end ? 8'd0 : new_run.length;
            run_open_next   = !in_end;
        end
    end

    // Run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= 8'd0;
            run_length_reg <= 8'd0;
            run_open_reg   <= 1'b0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

endmodule

// File: rtl/erle_queue.sv
// Short queue of run requests between the front and the back of the RLE encoder.
// Depends on erle_pkg for the request type and the depth.
module erle_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  erle_pkg::emit_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output erle_pkg::emit_cmd_t head_cmd
);

    erle_pkg::emit_cmd_t                entries_reg [erle_pkg::QUEUE_DEPTH];
    logic [erle_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [erle_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [erle_pkg::QCNT_W-1:0]        count_reg,  count_next;

    assign full       = (count_reg == erle_pkg::QCNT_W'(erle_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/erle_back.sv
// Back part of the escape-byte RLE encoder: walks the queued request byte by byte
// into a registered output stage. Depends on erle_pkg.
module erle_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  erle_pkg::emit_cmd_t head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_item_last,
    output logic                out_stream_end
);

    logic [erle_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_end_reg,  out_end_next;

    logic                       load;
    logic [erle_pkg::POS_W-1:0] first_len;
    logic [erle_pkg::POS_W-1:0] total_len;
    logic [erle_pkg::POS_W-1:0] second_pos;
    logic                       final_byte;
    logic [7:0]                 cur_byte;

    // Pick the byte at the current position of the head request.
    always_comb
    begin
        first_len  = erle_pkg::run_bytes(head_cmd.first_run);
        total_len  = first_len;
        if (head_cmd.two_runs)
        begin
            total_len = first_len + erle_pkg::run_bytes(head_cmd.second_run);
        end
        second_pos = pos_reg - first_len;
        if (pos_reg < first_len)
        begin
            cur_byte = erle_pkg::run_byte(head_cmd.first_run, pos_reg[1:0]);
        end
        else
        begin
            cur_byte = erle_pkg::run_byte(head_cmd.second_run, second_pos[1:0]);
        end
        final_byte = (pos_reg == total_len - 1'b1);
    end

    // The output register takes a new byte whenever it is empty or being drained.
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && final_byte;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (load)
        begin
            pos_next       = final_byte ? '0 : pos_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = final_byte;
            out_end_next   = final_byte && head_cmd.stream_end;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_item_last  = out_last_reg;
    assign out_stream_end = out_end_reg;

endmodule

// File: rtl/escape_rle_byte_encoder_core.sv
// Top level of the escape-byte run-length encoder.
// Instantiates erle_front, erle_queue and erle_back; depends on erle_pkg.
//
// Usage:
//   The input channel (in_valid, in_ready, in_byte, in_end) takes one uncompressed
//   byte per request; in_end marks the last byte of a stream. The output channel
//   (out_valid, out_ready, out_byte, out_item_last, out_stream_end) gives one
//   compressed byte per request. A repeated run goes out as 0xFF, count, value;
//   a single byte goes out as itself, except a lone 0xFF, which is sent as a triple.
//   out_item_last flags the last byte caused by one input; out_stream_end the last
//   byte of the compressed stream.
//   Throughput: one input byte per cycle while the queue is not full. The front
//   classifies a byte in the cycle it is accepted and queues up to two closed runs;
//   the back emits one output byte per cycle while the receiver takes them, so a
//   triple keeps the back busy for three output bytes and a byte that closes two runs
//   for up to six. The four-entry queue absorbs this; in_ready falls only when the
//   queue is full. A closed run is written into the queue when its input is accepted;
//   its first byte is loaded into the output register once it reaches the head.
//   Reset clears the open run and empties the queue and the output stage. When the
//   receiver stalls, the output byte holds, the queue fills and then the input stalls.
module escape_rle_byte_encoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_item_last,
    output logic       out_stream_end
);

    logic                queue_full;
    logic                push;
    erle_pkg::emit_cmd_t push_cmd;
    logic                pop;
    logic                head_valid;
    erle_pkg::emit_cmd_t head_cmd;

    // Front: run tracking and request generation.
    erle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_end     (in_end),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Queue of closed runs.
    erle_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: byte serialiser and output register.
    erle_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_item_last  (out_item_last),
        .out_stream_end (out_stream_end)
    );

endmodule

// File: tb/sv/escape_rle_byte_encoder_core_tb.sv
// Self-checking testbench for the escape-byte run-length encoder core.
// Depends on erle_pkg and escape_rle_byte_encoder_core, and through the core on erle_front, erle_queue and erle_back.
module escape_rle_byte_encoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 220;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 20;

    // One compressed output byte with its flags.
    typedef struct packed {
        logic [7:0] data;
        logic       item_last;
        logic       stream_end;
    } coded_byte_t;

    // Tracks the encoder state and holds the bytes still due from the block.
    class encoded_byte_checker;
        logic [7:0]  held_value;
        logic [7:0]  run_length;
        logic        run_open;
        coded_byte_t due_bytes[$];
        int          mismatch_count;

        function new();
            held_value     = '0;
            run_length     = '0;
            run_open       = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void push_byte(logic [7:0] b);
            coded_byte_t cb;
            cb.data       = b;
            cb.item_last  = 1'b0;
            cb.stream_end = 1'b0;
            due_bytes.insert(due_bytes.size(), cb);
        endfunction

        // A repeated run, or a lone escape byte, goes out as a triple.
        function void close_run();
            if (run_length > 8'd1 || held_value == erle_pkg::ESCAPE_BYTE)
            begin
                push_byte(erle_pkg::ESCAPE_BYTE);
                push_byte(run_length);
                push_byte(held_value);
            end
            else
            begin
                push_byte(held_value);
            end
        endfunction

        // Works out the bytes that one accepted request causes.
        function void encode_request(logic [7:0] b, logic last_of_stream);
            int          before_count;
            coded_byte_t tail;
            before_count = due_bytes.size();
            if (run_open && (b != held_value || run_length >= erle_pkg::RUN_CAP))
            begin
                close_run();
                run_open = 1'b0;
            end
            if (run_open)
            begin
                run_length = run_length + 8'd1;
            end
            else
            begin
                held_value = b;
                run_length = 8'd1;
                run_open   = 1'b1;
            end
            if (last_of_stream)
            begin
                close_run();
                run_open   = 1'b0;
                run_length = '0;
            end
            // Flag the final byte caused by this request.
            if (due_bytes.size() > before_count)
            begin
                tail = due_bytes[due_bytes.size() - 1];
                tail.item_last  = 1'b1;
                tail.stream_end = last_of_stream;
                due_bytes[due_bytes.size() - 1] = tail;
            end
        endfunction

        // Compares one output byte with the oldest byte still due.
        function void check_output_byte(logic [7:0] b, logic item_last, logic stream_end);
            coded_byte_t want;
            if (due_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected output byte %02h last=%0b end=%0b",
                             $realtime, b, item_last, stream_end);
                return;
            end
            want = due_bytes.pop_front();
            if (want.data !== b || want.item_last !== item_last
                || want.stream_end !== stream_end)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: expected byte %02h last=%0b end=%0b, got %02h last=%0b end=%0b",
                             $realtime, want.data, want.item_last, want.stream_end,
                             b, item_last, stream_end);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_item_last;
    logic       out_stream_end;

    encoded_byte_checker sb;
    bit                  no_idle;
    int                  requests_sent;
    int                  cycle_count = 0;

    escape_rle_byte_encoder_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .in_end         (in_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_item_last  (out_item_last),
        .out_stream_end (out_stream_end)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Sends one request and notes it once the block has taken it.
    task automatic send_request(input logic [7:0] b, input logic last_of_stream);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= last_of_stream;
        do
            @(posedge clk);
        while (!in_ready);
        sb.encode_request(b, last_of_stream);
        requests_sent++;
    endtask

    // Holds the sender back until every due byte has come out.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // A stream of runs with random content, or now and then plain noise.
    task automatic send_random_stream();
        int         runs;
        int         run_len;
        int         p;
        logic [7:0] value;
        logic [7:0] prev_value;
        prev_value = 8'($urandom_range(0, 255));
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 8))
                send_request(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            return;
        end
        runs = $urandom_range(1, 5);
        for (int r = 0; r < runs; r++)
        begin
            p = $urandom_range(0, 99);
            if (p < 15)
                value = erle_pkg::ESCAPE_BYTE;
            else if (p < 25)
                value = 8'h00;
            else if (p < 35)
                value = prev_value;
            else
                value = 8'($urandom_range(0, 255));
            p = $urandom_range(0, 99);
            if (p < 60)
                run_len = 1;
            else if (p < 90)
                run_len = $urandom_range(2, 4);
            else
                run_len = $urandom_range(5, 20);
            for (int i = 0; i < run_len; i++)
                send_request(value, (r == runs - 1) && (i == run_len - 1));
            prev_value = value;
        end
    endtask

    // Receiver: bursts of ready broken by random stalls.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Check every byte the receiver takes.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_output_byte(out_byte, out_item_last, out_stream_end);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Main sequence: reset, directed cases, random streams, then the verdict.
    initial
    begin
        logic [7:0] long_value;
        int         long_len;
        int         random_goal;
        sb            = new();
        no_idle       = 1'b0;
        requests_sent = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        in_end    <= 1'b0;
        out_ready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lone bytes at both extremes, the escape byte among them.
        send_request(8'h00, 1'b1);
        send_request(erle_pkg::ESCAPE_BYTE, 1'b1);
        // A short repeated run.
        send_request(8'h55, 1'b0);
        send_request(8'h55, 1'b0);
        send_request(8'h55, 1'b1);
        // A byte change closes a single byte.
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b1);
        // A run of escapes closed by a change that also ends the stream.
        send_request(erle_pkg::ESCAPE_BYTE, 1'b0);
        send_request(erle_pkg::ESCAPE_BYTE, 1'b0);
        send_request(8'h00, 1'b1);
        // Two triples from one request: six bytes.
        send_request(8'hAA, 1'b0);
        send_request(8'hAA, 1'b0);
        send_request(erle_pkg::ESCAPE_BYTE, 1'b1);
        // A lone escape in mid-stream.
        send_request(erle_pkg::ESCAPE_BYTE, 1'b0);
        send_request(8'h01, 1'b1);
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(8'h7F, 1'b1);
        drain_outputs();

        // A run that reaches the cap of 255 and goes a little past it.
        long_value = 8'($urandom_range(0, 255));
        long_len   = 255 + $urandom_range(0, 3);
        for (int i = 0; i < long_len; i++)
            send_request(long_value, 1'b0);
        send_request(long_value ^ 8'h01, 1'b1);

        // Random streams, with an occasional full drain.
        random_goal = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < random_goal)
        begin
            send_random_stream();
            if ($urandom_range(0, 19) == 0)
                drain_outputs();
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
